@@ src/union_find_path_halving_core_macros.svh @@
// assertion helpers shared by the core modules
`ifndef UNION_FIND_PATH_HALVING_CORE_MACROS_SVH
`define UNION_FIND_PATH_HALVING_CORE_MACROS_SVH

// checked property, masked while reset is low
`define UFPH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked property, also live during reset
`define UFPH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/ufph_pkg.sv @@
package ufph_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int IDX_W            = 10;
    localparam int CFG_W            = 11;
    localparam logic [CFG_W-1:0] COUNT_RESET = 11'd1024;

    // request codes, code 3 is rejected
    localparam logic [1:0] OP_FIND      = 2'd0;
    localparam logic [1:0] OP_UNION     = 2'd1;
    localparam logic [1:0] OP_CONNECTED = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] first_element;
        logic [IDX_W-1:0] second_element;
    } t_in_item;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] root;
        logic             same_set;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_HALVE,
        ST_SIZE_P,
        ST_SIZE_Q,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic start;
        logic halve_rd;
        logic halve_wr;
        logic start_q;
        logic size_rd_p;
        logic size_cap;
        logic link;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_err;
        logic at_root;
        logic phase_q;
        logic op_find;
        logic op_union;
        logic roots_equal;
        logic out_free;
    } t_dp_stat;

endpackage

@@ src/union_find_path_halving_core.sv @@
// disjoint-set engine: weighted union with path halving over a parent table
// input channel i_in_valid / o_in_stall carries one request (find, union,
// connected); a transfer happens when valid is high and stall is low
// output channel o_out_valid / i_out_stall returns exactly one result per request
// i_cfg_we writes element_count; indices at or above it get status 1
// sequence: accept, then per walk a root check, alternating with halving steps until
// it finds the root; union adds the size read and link states; then the result
// a rejected request goes from accept straight to its result
// each halving step lifts the walk two levels, bounded by the one read port
// of the parent memory; weighting keeps trees at log2(element_count) depth or less
// reset starts a clearing pass over all MAX_ELEMENTS entries, one entry per cycle,
// during which stall is held high; configuration writes are taken throughout
// a finished result sits in the output register while the next request is
// accepted; a stalled receiver only holds a request once it reaches its result
module union_find_path_halving_core #(
    parameter int MAX_ELEMENTS = ufph_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ufph_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ufph_pkg::t_out_item        o_out_data,
    input  logic                       i_cfg_we,
    input  logic [ufph_pkg::CFG_W-1:0] i_cfg_data
);
    import ufph_pkg::*;

    // command and status between sequencer and tables
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: clearing pass, walks, size compare, result hand-off
    ufph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // parent and size memories, walk registers, output register
    ufph_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

@@ src/ufph_ctrl.sv @@
`include "union_find_path_halving_core_macros.svh"

module ufph_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ufph_pkg::t_dp_stat i_stat,
    output ufph_pkg::t_dp_cmd  o_cmd
);
    import ufph_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_stat.in_err ? ST_RESULT : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_stat.at_root) begin
                    o_cmd.halve_rd = 1'b1;
                    n_state        = ST_HALVE;
                end else if (!i_stat.phase_q) begin
                    if (i_stat.op_find) begin
                        n_state = ST_RESULT;
                    end else begin
                        o_cmd.start_q = 1'b1;
                    end
                end else if (i_stat.op_union && !i_stat.roots_equal) begin
                    o_cmd.size_rd_p = 1'b1;
                    n_state         = ST_SIZE_P;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_HALVE: begin
                o_cmd.halve_wr = 1'b1;
                n_state        = ST_CHECK;
            end
            ST_SIZE_P: begin
                o_cmd.size_cap = 1'b1;
                n_state        = ST_SIZE_Q;
            end
            ST_SIZE_Q: begin
                o_cmd.link = 1'b1;
                n_state    = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    `UFPH_ASSERT(a_load_needs_room, o_cmd.out_load |-> i_stat.out_free, "result loaded over a held one")
    `UFPH_ASSERT(a_no_walk_on_error, (o_cmd.start && i_stat.in_err) |=> (r_state == ST_RESULT), "bad request started a walk")

endmodule

@@ src/ufph_dp.sv @@
`include "union_find_path_halving_core_macros.svh"

module ufph_dp #(
    parameter int MAX_ELEMENTS = ufph_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ufph_pkg::t_in_item          i_in_data,
    input  logic                        i_cfg_we,
    input  logic [ufph_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output ufph_pkg::t_out_item         o_out_data,
    input  ufph_pkg::t_dp_cmd           i_cmd,
    output ufph_pkg::t_dp_stat          o_stat
);
    import ufph_pkg::*;

    localparam int AW     = $clog2(MAX_ELEMENTS);
    localparam int SW     = $clog2(MAX_ELEMENTS + 1);
    localparam int CMP_W  = (SW > CFG_W) ? SW : CFG_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ELEMENTS);
    localparam logic [AW-1:0]    LAST    = AW'(MAX_ELEMENTS - 1);

    logic [AW-1:0] mem_par  [MAX_ELEMENTS];
    logic [SW-1:0] mem_size [MAX_ELEMENTS];

    logic [CFG_W-1:0] r_count;
    logic [AW-1:0]    r_clr;
    logic [1:0]       r_op;
    logic             r_err;
    logic [AW-1:0]    r_q;
    logic [AW-1:0]    r_x;
    logic [AW-1:0]    r_rp;
    logic             r_phase_q;
    logic [AW-1:0]    r_par_rd;
    logic [SW-1:0]    r_size_rd;
    logic [SW-1:0]    r_szp;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [CMP_W-1:0] lim;
    logic             p_ok;
    logic             q_ok;
    logic             in_err;
    logic [AW-1:0]    par_ra;
    logic             par_we;
    logic [AW-1:0]    par_wa;
    logic [AW-1:0]    par_wd;
    logic [AW-1:0]    size_ra;
    logic             size_we;
    logic [AW-1:0]    size_wa;
    logic [SW-1:0]    size_wd;
    logic             p_smaller;
    logic [SW-1:0]    size_sum;

    // range check against the effective element count
    always_comb begin
        lim    = (CMP_W'(r_count) > MAX_CMP) ? MAX_CMP : CMP_W'(r_count);
        p_ok   = CMP_W'(i_in_data.first_element) < lim;
        q_ok   = CMP_W'(i_in_data.second_element) < lim;
        in_err = (i_in_data.opcode != OP_FIND && i_in_data.opcode != OP_UNION
                  && i_in_data.opcode != OP_CONNECTED)
                 || !p_ok || (i_in_data.opcode != OP_FIND && !q_ok);
    end

    assign p_smaller = r_szp < r_size_rd;
    assign size_sum  = r_szp + r_size_rd;

    always_comb begin
        if (i_cmd.start) begin
            par_ra = AW'(i_in_data.first_element);
        end else if (i_cmd.start_q) begin
            par_ra = r_q;
        end else if (i_cmd.halve_rd || i_cmd.halve_wr) begin
            par_ra = r_par_rd;
        end else begin
            par_ra = r_x;
        end

        par_we = 1'b0;
        par_wa = r_x;
        par_wd = r_par_rd;
        if (i_cmd.clr_step) begin
            par_we = 1'b1;
            par_wa = r_clr;
            par_wd = r_clr;
        end else if (i_cmd.halve_wr) begin
            par_we = 1'b1;
        end else if (i_cmd.link) begin
            par_we = 1'b1;
            par_wa = p_smaller ? r_rp : r_x;
            par_wd = p_smaller ? r_x : r_rp;
        end

        size_ra = i_cmd.size_rd_p ? r_rp : r_x;
        size_we = 1'b0;
        size_wa = r_clr;
        size_wd = SW'(1);
        if (i_cmd.clr_step) begin
            size_we = 1'b1;
        end else if (i_cmd.link) begin
            size_we = 1'b1;
            size_wa = p_smaller ? r_x : r_rp;
            size_wd = size_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (par_we) begin
            mem_par[par_wa] <= par_wd;
        end
        r_par_rd <= mem_par[par_ra];
    end

    always_ff @(posedge i_clk) begin
        if (size_we) begin
            mem_size[size_wa] <= size_wd;
        end
        r_size_rd <= mem_size[size_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_RESET;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op      <= i_in_data.opcode;
            r_err     <= in_err;
            r_q       <= AW'(i_in_data.second_element);
            r_x       <= AW'(i_in_data.first_element);
            r_phase_q <= 1'b0;
        end else if (i_cmd.start_q) begin
            r_rp      <= r_x;
            r_x       <= r_q;
            r_phase_q <= 1'b1;
        end else if (i_cmd.halve_wr) begin
            r_x <= r_par_rd;
        end
        if (i_cmd.size_cap) begin
            r_szp <= r_size_rd;
        end
        if (i_cmd.out_load) begin
            r_out.status   <= r_err;
            r_out.root     <= (!r_err && r_op == OP_FIND) ? IDX_W'(r_x) : '0;
            r_out.same_set <= !r_err && r_op == OP_CONNECTED && r_rp == r_x;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_stat.clr_last    = r_clr == LAST;
        o_stat.in_err      = in_err;
        o_stat.at_root     = r_par_rd == r_x;
        o_stat.phase_q     = r_phase_q;
        o_stat.op_find     = r_op == OP_FIND;
        o_stat.op_union    = r_op == OP_UNION;
        o_stat.roots_equal = r_rp == r_x;
        o_stat.out_free    = !r_out_valid || !i_out_stall;
    end

    `UFPH_ASSERT(a_halve_not_self, i_cmd.halve_wr |-> (r_par_rd != r_x), "halving step on a root")
    `UFPH_ASSERT(a_link_two_roots, i_cmd.link |-> (r_rp != r_x), "link of a tree to itself")

endmodule

@@ sim/tb_union_find_path_halving_core.sv @@
module tb_union_find_path_halving_core;

    import ufph_pkg::t_in_item;
    import ufph_pkg::t_out_item;
    import ufph_pkg::OP_FIND;
    import ufph_pkg::OP_UNION;
    import ufph_pkg::OP_CONNECTED;

    localparam int N_ELEM = ufph_pkg::MAX_ELEMENTS_DEF;
    localparam int IDX_W  = ufph_pkg::IDX_W;
    localparam int CFG_W  = ufph_pkg::CFG_W;

    // request code with no operation behind it, answered as an error
    localparam logic [1:0] OP_UNUSED        = 2'd3;
    localparam logic       STATUS_OK        = 1'b0;
    localparam logic       STATUS_RANGE_ERR = 1'b1;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 417;
    localparam int DRAIN_CYCLES    = 64;

    // one row of the directed sequence; want_* is only used when typed is set
    typedef struct packed {
        logic             set_cnt;
        logic [CFG_W-1:0] cnt;
        logic [1:0]       op;
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] q;
        logic             typed;
        logic             want_status;
        logic [IDX_W-1:0] want_root;
        logic             want_same;
    } t_dir_row;

    localparam int N_DIRECTED = 24;
    localparam t_dir_row DIRECTED_ROWS [N_DIRECTED] = '{
        // fresh tables: every element is its own root
        '{1'b0, 11'd0, OP_FIND, 10'd0, 10'd1023, 1'b1, STATUS_OK, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_FIND, 10'd1023, 10'd0, 1'b1, STATUS_OK, 10'd1023, 1'b0},
        '{1'b0, 11'd0, OP_CONNECTED, 10'd0, 10'd1023, 1'b1, STATUS_OK, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_UNUSED, 10'd1023, 10'd1023, 1'b1, STATUS_RANGE_ERR, 10'd0, 1'b0},
        // equal sizes, smaller under larger, union inside one set
        '{1'b0, 11'd0, OP_UNION, 10'd0, 10'd1, 1'b0, 1'b0, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_UNION, 10'd2, 10'd3, 1'b0, 1'b0, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_UNION, 10'd1, 10'd3, 1'b0, 1'b0, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_UNION, 10'd1023, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_CONNECTED, 10'd3, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_UNION, 10'd2, 10'd3, 1'b0, 1'b0, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_FIND, 10'd1023, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_CONNECTED, 10'd1023, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b0},
        // zero count rejects everything
        '{1'b1, 11'd0, OP_FIND, 10'd0, 10'd0, 1'b1, STATUS_RANGE_ERR, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_UNION, 10'd0, 10'd0, 1'b1, STATUS_RANGE_ERR, 10'd0, 1'b0},
        // single element in use
        '{1'b1, 11'd1, OP_FIND, 10'd0, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_CONNECTED, 10'd0, 10'd1, 1'b1, STATUS_RANGE_ERR, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_UNION, 10'd0, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        // count above the table size behaves as the table size
        '{1'b1, 11'd2047, OP_FIND, 10'd1023, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_CONNECTED, 10'd1023, 10'd512, 1'b0, 1'b0, 10'd0, 1'b0},
        // shrunk count: old links stay, find ignores q
        '{1'b1, 11'd3, OP_FIND, 10'd2, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_FIND, 10'd3, 10'd0, 1'b1, STATUS_RANGE_ERR, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_UNION, 10'd0, 10'd3, 1'b1, STATUS_RANGE_ERR, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_CONNECTED, 10'd3, 10'd0, 1'b1, STATUS_RANGE_ERR, 10'd0, 1'b0},
        '{1'b0, 11'd0, OP_UNUSED, 10'd0, 10'd0, 1'b1, STATUS_RANGE_ERR, 10'd0, 1'b0}
    };

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             in_valid   = 1'b0;
    logic             out_stall  = 1'b0;
    logic             cfg_we     = 1'b0;
    logic [CFG_W-1:0] cfg_data   = '0;
    t_in_item         in_data    = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_item        o_out_data;

    int src_idle_pct = 17;
    int dst_idle_pct = 86;
    int mismatch_count = 0;
    int cycle_count = 0;

    // own copy of the disjoint-set state
    logic [IDX_W-1:0] parent_of [N_ELEM];
    int               set_size  [N_ELEM];
    logic [CFG_W-1:0] count_setting;

    // hot window so that random unions build deep trees
    int hot_base;
    int hot_len;

    t_out_item expected_results [$];

    union_find_path_halving_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < dst_idle_pct);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic bit index_ok(input logic [IDX_W-1:0] idx);
        int lim;
        lim = (count_setting > N_ELEM) ? N_ELEM : int'(count_setting);
        return int'(idx) < lim;
    endfunction

    // walk to the root, re-pointing every visited node at its grandparent
    function automatic logic [IDX_W-1:0] halve_to_root(input logic [IDX_W-1:0] start);
        logic [IDX_W-1:0] node;
        int               steps;
        node  = start;
        steps = 0;
        while (parent_of[node] != node && steps < N_ELEM) begin
            parent_of[node] = parent_of[parent_of[node]];
            node = parent_of[node];
            steps++;
        end
        return node;
    endfunction

    function automatic t_out_item predict_result(input t_in_item req);
        t_out_item        res;
        logic [IDX_W-1:0] rp;
        logic [IDX_W-1:0] rq;
        res = '{status: STATUS_RANGE_ERR, root: '0, same_set: 1'b0};
        case (req.opcode)
            OP_FIND: begin
                if (index_ok(req.first_element)) begin
                    res.root   = halve_to_root(req.first_element);
                    res.status = STATUS_OK;
                end
            end
            OP_UNION: begin
                if (index_ok(req.first_element) && index_ok(req.second_element)) begin
                    rp = halve_to_root(req.first_element);
                    rq = halve_to_root(req.second_element);
                    res.status = STATUS_OK;
                    // smaller tree goes under the larger, ties keep p's root on top
                    if (rp != rq) begin
                        if (set_size[rp] < set_size[rq]) begin
                            parent_of[rp] = rq;
                            set_size[rq] += set_size[rp];
                        end else begin
                            parent_of[rq] = rp;
                            set_size[rp] += set_size[rq];
                        end
                    end
                end
            end
            OP_CONNECTED: begin
                if (index_ok(req.first_element) && index_ok(req.second_element)) begin
                    rp = halve_to_root(req.first_element);
                    rq = halve_to_root(req.second_element);
                    res.same_set = (rp == rq);
                    res.status   = STATUS_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int r;
        int lim;
        r   = $urandom_range(0, 99);
        lim = (count_setting > N_ELEM) ? N_ELEM : int'(count_setting);
        if (r < 75)
            return IDX_W'(hot_base + $urandom_range(0, hot_len - 1));
        else if (r < 92)
            return IDX_W'($urandom_range(0, lim - 1));
        else
            return IDX_W'($urandom_range(0, N_ELEM - 1));
    endfunction

    function automatic t_in_item next_request();
        t_in_item req;
        int       sel;
        sel = $urandom_range(0, 99);
        if (sel < 42)
            req.opcode = OP_UNION;
        else if (sel < 68)
            req.opcode = OP_FIND;
        else if (sel < 95)
            req.opcode = OP_CONNECTED;
        else
            req.opcode = OP_UNUSED;
        req.first_element  = pick_index();
        req.second_element = pick_index();
        return req;
    endfunction

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic issue_request(input t_in_item req, input bit typed, input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_result(req);
        expected_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // only once the engine has gone quiet
    task automatic set_element_count(input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        count_setting = value;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing outstanding");
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_out_data.status, want.status));
                if (o_out_data.root !== want.root)
                    report_mismatch($sformatf("root got %0d want %0d",
                                              o_out_data.root, want.root));
                if (o_out_data.same_set !== want.same_set)
                    report_mismatch($sformatf("same_set got %0d want %0d",
                                              o_out_data.same_set, want.same_set));
            end
        end
    end

    initial begin
        t_in_item  req;
        t_out_item want;
        int        lim;
        for (int i = 0; i < N_ELEM; i++) begin
            parent_of[i] = IDX_W'(i);
            set_size[i]  = 1;
        end
        count_setting = ufph_pkg::COUNT_RESET;
        hot_base = 0;
        hot_len  = 1;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed sequence, clearing pass shows up as stall on the first request
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED_ROWS[i].set_cnt)
                set_element_count(DIRECTED_ROWS[i].cnt);
            req.opcode         = DIRECTED_ROWS[i].op;
            req.first_element  = DIRECTED_ROWS[i].p;
            req.second_element = DIRECTED_ROWS[i].q;
            want.status        = DIRECTED_ROWS[i].want_status;
            want.root          = DIRECTED_ROWS[i].want_root;
            want.same_set      = DIRECTED_ROWS[i].want_same;
            issue_request(req, DIRECTED_ROWS[i].typed, want);
        end

        // random phases: slow receiver, slow sender, then full rate
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 17;
                    dst_idle_pct = 86;
                    set_element_count(11'd1024);
                    hot_len = 96;
                end
                1: begin
                    src_idle_pct = 86;
                    dst_idle_pct = 17;
                    set_element_count(CFG_W'($urandom_range(40, 300)));
                    hot_len = 32;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                    set_element_count(CFG_W'($urandom_range(600, 1023)));
                    hot_len = 128;
                end
            endcase
            lim = (count_setting > N_ELEM) ? N_ELEM : int'(count_setting);
            hot_base = $urandom_range(0, lim - hot_len);
            repeat (ITEMS_PER_PHASE)
                issue_request(next_request(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ union_find_path_halving_core.f @@
+incdir+src
src/ufph_pkg.sv
src/ufph_ctrl.sv
src/ufph_dp.sv
src/union_find_path_halving_core.sv
sim/tb_union_find_path_halving_core.sv
